[src/ctmt_pkg.sv]
`default_nettype none

package ctmt_pkg;

  // Longest token is MAX_TOKEN_LEN-1 bytes; the length counter only needs to reach that.
  localparam int unsigned MAX_TOKEN_LEN = 512;
  localparam int unsigned TOK_LEN_W     = $clog2(MAX_TOKEN_LEN);

  // One input byte causes at most four results.
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);

  // Depth of the queue between parser and output stage, in bundles.
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_CTCP   = 8'h01;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [4:0] OCT_HIGH  = 5'b00110;

  typedef enum logic [1:0] {
    POS_FIRST,
    POS_SECOND,
    POS_BODY
  } pos_e;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_SEEN,
    ESC_OCTAL
  } esc_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       token_last;
    logic       message_end;
    logic       rejected;
    logic       overflowed;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [NRES_W-1:0]         cnt;
  } bundle_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
  } q_stat_t;

  typedef struct packed {
    logic [7:0]           held_byte;
    logic                 held_valid;
    logic [TOK_LEN_W-1:0] len;
    logic                 ovf;
  } tok_state_t;

  typedef struct packed {
    tok_state_t st;
    logic       emit;
    result_t    res;
  } tok_op_t;

  function automatic logic is_octal(logic [7:0] b);
    return b[7:3] == OCT_HIGH;
  endfunction

  // Unless full, appends a decoded byte; the previously held byte goes out as a result.
  function automatic tok_op_t tok_add(tok_state_t s, logic [7:0] b);
    tok_op_t r;
    r      = '0;
    r.st   = s;
    if (s.len >= TOK_LEN_W'(MAX_TOKEN_LEN - 1)) begin
      r.st.ovf = 1'b1;
    end else begin
      r.emit             = s.held_valid;
      r.res.out_byte     = s.held_byte;
      r.res.byte_present = 1'b1;
      r.st.held_byte     = b;
      r.st.held_valid    = 1'b1;
      r.st.len           = s.len + TOK_LEN_W'(1);
    end
    return r;
  endfunction

  // Closes the current token; the held byte goes out marked as last.
  function automatic tok_op_t tok_end(tok_state_t s);
    tok_op_t r;
    r                  = '0;
    r.st               = s;
    r.emit             = s.held_valid;
    r.res.out_byte     = s.held_byte;
    r.res.byte_present = 1'b1;
    r.res.token_last   = 1'b1;
    r.st.held_valid    = 1'b0;
    r.st.held_byte     = '0;
    r.st.len           = '0;
    return r;
  endfunction

endpackage

`default_nettype wire

[src/ctcp_message_tokenizer_core.sv]
`default_nettype none

// Channel  Dir  tdata (low bit up)                                  tlast           tuser
// s_axis   in   in_byte[7:0]                                        end_of_message  -
// m_axis   out  out_byte[7:0], message_end, rejected, overflowed,   token_last      byte_present
//               zeros up to bit 15
//
// A byte is accepted in every cycle in which the parser-to-output queue (4 bundles) has room.
// Each byte yields zero to four results; the output register sends one result per cycle while
// the receiver is ready, so a byte that makes k results keeps the output side busy for k transfers.
// The first result of a byte is registered in the queue and then in the output register
// before it becomes valid; it waits longer while earlier results still occupy the output.
// Reset is immediate; there is no clearing pass. Either side may stall independently.
module ctcp_message_tokenizer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // in_byte
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // out_byte, message_end, rejected, overflowed
  output logic             m_axis_tlast_o,
  output logic             m_axis_tuser_o    // byte_present
);

  ctmt_pkg::q_stat_t stat;
  ctmt_pkg::bundle_t push_bundle;
  ctmt_pkg::bundle_t head;
  ctmt_pkg::result_t res;
  logic              push;
  logic              pop;
  logic              fire;

  assign s_axis_tready_o = !stat.full;
  assign fire            = s_axis_tvalid_i && s_axis_tready_o;

  ctmt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_byte_i (s_axis_tdata_i),
    .eom_i     (s_axis_tlast_i),
    .stat_i    (stat),
    .bundle_o  (push_bundle),
    .push_o    (push)
  );

  ctmt_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_bundle_i (push_bundle),
    .pop_i         (pop),
    .head_o        (head),
    .stat_o        (stat)
  );

  ctmt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {5'b0, res.overflowed, res.rejected, res.message_end, res.out_byte};
  assign m_axis_tlast_o = res.token_last;
  assign m_axis_tuser_o = res.byte_present;

endmodule

`default_nettype wire

[src/ctmt_front.sv]
`default_nettype none

module ctmt_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               eom_i,
  input  wire ctmt_pkg::q_stat_t  stat_i,
  output ctmt_pkg::bundle_t       bundle_o,
  output logic                    push_o
);

  ctmt_pkg::pos_e       pos_q, pos_d;
  ctmt_pkg::esc_e       esc_q, esc_d;
  logic                 rej_q, rej_d;
  logic [7:0]           acc_q, acc_d;
  logic                 quo_q, quo_d;
  ctmt_pkg::tok_state_t ts_q, ts_d;
  ctmt_pkg::bundle_t    bnd;

  always_comb begin
    ctmt_pkg::tok_op_t op;
    logic              do_parse;
    logic              do_plain;
    logic [7:0]        b;
    b        = in_byte_i;
    pos_d    = pos_q;
    esc_d    = esc_q;
    rej_d    = rej_q;
    acc_d    = acc_q;
    quo_d    = quo_q;
    ts_d     = ts_q;
    bnd      = '0;
    op       = '0;
    do_parse = 1'b0;
    do_plain = 1'b0;

    if (!rej_d) begin
      case (pos_q)
        ctmt_pkg::POS_FIRST: begin
          if (b != ctmt_pkg::CH_CTCP) rej_d = 1'b1;
          pos_d = ctmt_pkg::POS_SECOND;
        end
        ctmt_pkg::POS_SECOND: begin
          if (b == ctmt_pkg::CH_CTCP || b == ctmt_pkg::CH_NUL) rej_d = 1'b1;
          else do_parse = 1'b1;
          pos_d = ctmt_pkg::POS_BODY;
        end
        default: begin
          do_parse = 1'b1;
        end
      endcase
    end

    if (do_parse) begin
      case (esc_q)
        ctmt_pkg::ESC_SEEN: begin
          esc_d = ctmt_pkg::ESC_NONE;
          if (ctmt_pkg::is_octal(b)) begin
            acc_d = {5'b0, b[2:0]};
            esc_d = ctmt_pkg::ESC_OCTAL;
          end else if (b != ctmt_pkg::CH_NUL) begin
            op   = ctmt_pkg::tok_add(ts_d, b);
            ts_d = op.st;
            if (op.emit) begin
              bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0]] = op.res;
              bnd.cnt = bnd.cnt + ctmt_pkg::NRES_W'(1);
            end
          end
        end
        ctmt_pkg::ESC_OCTAL: begin
          if (ctmt_pkg::is_octal(b)) begin
            acc_d = {acc_q[4:0], b[2:0]};
          end else begin
            // Octal run ends; flush a non-zero value, then treat b as plain.
            esc_d = ctmt_pkg::ESC_NONE;
            if (acc_q != 8'h00) begin
              op   = ctmt_pkg::tok_add(ts_d, acc_q);
              ts_d = op.st;
              if (op.emit) begin
                bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0]] = op.res;
                bnd.cnt = bnd.cnt + ctmt_pkg::NRES_W'(1);
              end
            end
            acc_d    = '0;
            do_plain = 1'b1;
          end
        end
        default: begin
          do_plain = 1'b1;
        end
      endcase
    end

    if (do_plain) begin
      op = '0;
      if (b == ctmt_pkg::CH_BSLASH) begin
        esc_d = ctmt_pkg::ESC_SEEN;
      end else if (b == ctmt_pkg::CH_SPACE) begin
        if (quo_q) op = ctmt_pkg::tok_add(ts_d, b);
        else       op = ctmt_pkg::tok_end(ts_d);
        ts_d = op.st;
      end else if (b == ctmt_pkg::CH_QUOTE) begin
        op    = ctmt_pkg::tok_end(ts_d);
        ts_d  = op.st;
        quo_d = ~quo_q;
      end else if (b != ctmt_pkg::CH_CTCP && b != ctmt_pkg::CH_NUL) begin
        op   = ctmt_pkg::tok_add(ts_d, b);
        ts_d = op.st;
      end
      if (op.emit) begin
        bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0]] = op.res;
        bnd.cnt = bnd.cnt + ctmt_pkg::NRES_W'(1);
      end
    end

    if (eom_i) begin
      if (pos_d != ctmt_pkg::POS_BODY) rej_d = 1'b1;
      if (!rej_d) begin
        if (esc_d == ctmt_pkg::ESC_OCTAL && acc_d != 8'h00) begin
          op   = ctmt_pkg::tok_add(ts_d, acc_d);
          ts_d = op.st;
          if (op.emit) begin
            bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0]] = op.res;
            bnd.cnt = bnd.cnt + ctmt_pkg::NRES_W'(1);
          end
        end
        op   = ctmt_pkg::tok_end(ts_d);
        ts_d = op.st;
        if (op.emit) begin
          bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0]] = op.res;
          bnd.cnt = bnd.cnt + ctmt_pkg::NRES_W'(1);
        end
      end
      bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0]]             = '0;
      bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0]].message_end = 1'b1;
      bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0]].rejected    = rej_d;
      bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0]].overflowed  = ~rej_d & ts_d.ovf;
      bnd.cnt = bnd.cnt + ctmt_pkg::NRES_W'(1);
      pos_d = ctmt_pkg::POS_FIRST;
      esc_d = ctmt_pkg::ESC_NONE;
      rej_d = 1'b0;
      acc_d = '0;
      quo_d = 1'b0;
      ts_d  = '0;
    end
  end

  assign bundle_o = bnd;
  assign push_o   = fire_i && (bnd.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= ctmt_pkg::POS_FIRST;
      esc_q <= ctmt_pkg::ESC_NONE;
      rej_q <= 1'b0;
      acc_q <= '0;
      quo_q <= 1'b0;
      ts_q  <= '0;
    end else if (fire_i) begin
      pos_q <= pos_d;
      esc_q <= esc_d;
      rej_q <= rej_d;
      acc_q <= acc_d;
      quo_q <= quo_d;
      ts_q  <= ts_d;
    end
  end

  a_eom_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && eom_i |-> push_o && bnd.res[bnd.cnt[ctmt_pkg::SLOT_W-1:0] - 1'b1].message_end)
    else $error("message end did not queue a closing marker");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !stat_i.full)
    else $error("bundle pushed into a full queue");

endmodule

`default_nettype wire

[src/ctmt_queue.sv]
`default_nettype none

module ctmt_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ctmt_pkg::bundle_t push_bundle_i,
  input  wire logic              pop_i,
  output ctmt_pkg::bundle_t      head_o,
  output ctmt_pkg::q_stat_t      stat_o
);

  ctmt_pkg::bundle_t                mem_q [ctmt_pkg::QDEPTH];
  logic [ctmt_pkg::QPTR_W-1:0]      wr_q, wr_d;
  logic [ctmt_pkg::QPTR_W-1:0]      rd_q, rd_d;
  logic [ctmt_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + ctmt_pkg::QPTR_W'(1) : wr_q;
    rd_d  = pop_i  ? rd_q + ctmt_pkg::QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + ctmt_pkg::QCNT_W'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - ctmt_pkg::QCNT_W'(1);
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == ctmt_pkg::QCNT_W'(ctmt_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ctmt_pkg::QCNT_W'(ctmt_pkg::QDEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[ctmt_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

[src/ctmt_back.sv]
`default_nettype none

module ctmt_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctmt_pkg::bundle_t head_i,
  input  wire ctmt_pkg::q_stat_t stat_i,
  output logic                   pop_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output ctmt_pkg::result_t      out_o
);

  logic [ctmt_pkg::SLOT_W-1:0] idx_q, idx_d;
  logic                        vld_q, vld_d;
  ctmt_pkg::result_t           out_q, out_d;
  logic                        load;
  logic                        at_tail;

  assign load    = !stat_i.empty && (!vld_q || out_ready_i);
  assign at_tail = (ctmt_pkg::NRES_W'(idx_q) + ctmt_pkg::NRES_W'(1)) >= head_i.cnt;
  assign pop_o   = load && at_tail;

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    out_d = out_q;
    if (load) begin
      out_d = head_i.res[idx_q];
      vld_d = 1'b1;
      idx_d = at_tail ? '0 : idx_q + ctmt_pkg::SLOT_W'(1);
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = out_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !stat_i.empty)
    else $error("pop from an empty queue");

  a_head_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_i.empty |-> head_i.cnt != '0 && ctmt_pkg::NRES_W'(idx_q) < head_i.cnt)
    else $error("serializer index outside head bundle");

endmodule

`default_nettype wire

[verif/ctcp_message_tokenizer_core_tb.sv]
`timescale 1ns / 100ps

module ctcp_message_tokenizer_core_tb;

  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_SEVEN = 8'h37;
  localparam logic [7:0] DIGIT_EIGHT = 8'h38;
  localparam logic [7:0] DIGIT_NINE  = 8'h39;
  localparam logic [7:0] LETTER_A    = 8'h61;
  localparam logic [7:0] LETTER_Z    = 8'h7A;
  localparam int         ITEM_TARGET = 260;
  localparam int         PRINT_CAP   = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } msg_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // in_byte
  logic        s_axis_tlast_i = 1'b0; // end_of_message
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // out_byte, message_end, rejected, overflowed
  logic        m_axis_tlast_o;        // token_last
  logic        m_axis_tuser_o;        // byte_present

  ctcp_message_tokenizer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Tokenizer state mirrored by the predictor.
  ctmt_pkg::pos_e    tk_pos;
  ctmt_pkg::esc_e    tk_esc;
  logic              tk_reject;
  logic              tk_ovf;
  logic              tk_quoted;
  logic [7:0]        tk_octal;
  logic [7:0]        tk_held;
  logic              tk_held_valid;
  logic [9:0]        tk_len;

  ctmt_pkg::result_t expected_results[$];
  msg_byte_t         pending_bytes[$];
  logic [7:0]        msg_build[$];
  msg_byte_t         next_byte;
  ctmt_pkg::result_t want;

  int  total_items = 0;
  int  accepted_items = 0;
  int  error_count = 0;
  int  messages_seen = 0;
  int  rejects_seen = 0;
  int  token_bytes_seen = 0;
  int  gap_left = 0;
  int  burst_left = 8;
  logic        byte_taken = 1'b0;
  logic [9:0]  stall_cycle = '0;

  function automatic void emit_expected(logic [7:0] b, logic present, logic last,
                                        logic mend, logic rej, logic ovf);
    ctmt_pkg::result_t r;
    r.out_byte     = b;
    r.byte_present = present;
    r.token_last   = last;
    r.message_end  = mend;
    r.rejected     = rej;
    r.overflowed   = ovf;
    expected_results.push_back(r);
  endfunction

  function automatic void tokenizer_clear();
    tk_pos        = ctmt_pkg::POS_FIRST;
    tk_esc        = ctmt_pkg::ESC_NONE;
    tk_reject     = 1'b0;
    tk_ovf        = 1'b0;
    tk_quoted     = 1'b0;
    tk_octal      = '0;
    tk_held       = '0;
    tk_held_valid = 1'b0;
    tk_len        = '0;
  endfunction

  // The previous byte is only released once the next one shows it was not the last.
  function automatic void token_append(logic [7:0] b);
    if (tk_len >= 10'(ctmt_pkg::MAX_TOKEN_LEN - 1)) begin
      tk_ovf = 1'b1;
    end else begin
      if (tk_held_valid) emit_expected(tk_held, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      tk_held       = b;
      tk_held_valid = 1'b1;
      tk_len        = tk_len + 10'd1;
    end
  endfunction

  function automatic void token_close();
    if (tk_held_valid) emit_expected(tk_held, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    tk_held_valid = 1'b0;
    tk_held       = '0;
    tk_len        = '0;
  endfunction

  function automatic void decode_plain(logic [7:0] b);
    if (b == ctmt_pkg::CH_BSLASH) begin
      tk_esc = ctmt_pkg::ESC_SEEN;
    end else if (b == ctmt_pkg::CH_SPACE) begin
      if (tk_quoted) token_append(b);
      else token_close();
    end else if (b == ctmt_pkg::CH_QUOTE) begin
      token_close();
      tk_quoted = !tk_quoted;
    end else if (b != ctmt_pkg::CH_CTCP && b != ctmt_pkg::CH_NUL) begin
      token_append(b);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic octal_digit;
    octal_digit = (b >= DIGIT_ZERO) && (b <= DIGIT_SEVEN);
    if (tk_esc == ctmt_pkg::ESC_SEEN) begin
      tk_esc = ctmt_pkg::ESC_NONE;
      if (octal_digit) begin
        tk_octal = b - DIGIT_ZERO;
        tk_esc   = ctmt_pkg::ESC_OCTAL;
      end else if (b != ctmt_pkg::CH_NUL) begin
        token_append(b);
      end
      return;
    end
    if (tk_esc == ctmt_pkg::ESC_OCTAL) begin
      if (octal_digit) begin
        tk_octal = {tk_octal[4:0], b[2:0]};
        return;
      end
      tk_esc = ctmt_pkg::ESC_NONE;
      if (tk_octal != 8'd0) token_append(tk_octal);
      tk_octal = '0;
    end
    decode_plain(b);
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eom);
    if (!tk_reject) begin
      case (tk_pos)
        ctmt_pkg::POS_FIRST: begin
          if (b != ctmt_pkg::CH_CTCP) tk_reject = 1'b1;
          tk_pos = ctmt_pkg::POS_SECOND;
        end
        ctmt_pkg::POS_SECOND: begin
          if (b == ctmt_pkg::CH_CTCP || b == ctmt_pkg::CH_NUL) tk_reject = 1'b1;
          else decode_byte(b);
          tk_pos = ctmt_pkg::POS_BODY;
        end
        default: decode_byte(b);
      endcase
    end
    if (eom) begin
      if (tk_pos != ctmt_pkg::POS_BODY) tk_reject = 1'b1;
      if (!tk_reject) begin
        if (tk_esc == ctmt_pkg::ESC_OCTAL && tk_octal != 8'd0) token_append(tk_octal);
        token_close();
      end
      emit_expected(8'h00, 1'b0, 1'b0, 1'b1, tk_reject, tk_reject ? 1'b0 : tk_ovf);
      tokenizer_clear();
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (error_count < PRINT_CAP)
      $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    error_count++;
  endtask

  task automatic queue_message(input logic drain_first);
    msg_byte_t item;
    for (int i = 0; i < msg_build.size(); i++) begin
      item.data  = msg_build[i];
      item.last  = (i == msg_build.size() - 1);
      item.drain = drain_first && (i == 0);
      pending_bytes.push_back(item);
    end
    total_items += msg_build.size();
    msg_build.delete();
  endtask

  task automatic push_letters(input int count);
    for (int i = 0; i < count; i++) msg_build.push_back(8'($urandom_range(LETTER_A, LETTER_Z)));
  endtask

  // Mostly plain letters, with separators, quotes and every escape form mixed in.
  task automatic random_body(input int n_elems);
    int kind;
    int digits;
    for (int e = 0; e < n_elems; e++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        push_letters(1);
      end else if (kind < 57) begin
        msg_build.push_back(ctmt_pkg::CH_SPACE);
      end else if (kind < 63) begin
        msg_build.push_back(ctmt_pkg::CH_QUOTE);
      end else if (kind < 75) begin
        msg_build.push_back(ctmt_pkg::CH_BSLASH);
        digits = $urandom_range(1, 4);
        for (int d = 0; d < digits; d++)
          msg_build.push_back(DIGIT_ZERO + 8'($urandom_range(0, 7)));
      end else if (kind < 80) begin
        msg_build.push_back(ctmt_pkg::CH_BSLASH);
        msg_build.push_back($urandom_range(0, 1) ? DIGIT_NINE : DIGIT_EIGHT);
      end else if (kind < 85) begin
        msg_build.push_back(ctmt_pkg::CH_BSLASH);
        msg_build.push_back($urandom_range(0, 3) == 0 ? ctmt_pkg::CH_NUL :
                            8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        msg_build.push_back($urandom_range(0, 1) ? ctmt_pkg::CH_CTCP : ctmt_pkg::CH_NUL);
      end else begin
        msg_build.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || byte_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_bytes.size() == 0 ||
                   (pending_bytes[0].drain && expected_results.size() != 0)) begin
        s_axis_tvalid_i <= 1'b0;
      end else begin
        next_byte = pending_bytes.pop_front();
        s_axis_tdata_i  <= next_byte.data;
        s_axis_tlast_i  <= next_byte.last;
        s_axis_tvalid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: cycles through always ready, a regular stall, random stalls and long stalls.
  always @(negedge clk_i) begin
    stall_cycle <= stall_cycle + 10'd1;
    case (stall_cycle[9:8])
      2'd0: m_axis_tready_i <= 1'b1;
      2'd1: m_axis_tready_i <= (stall_cycle[1:0] != 2'd3);
      2'd2: m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: m_axis_tready_i <= (stall_cycle[4:0] < 5'd20);
    endcase
  end

  // Input transfers feed the predictor; output transfers are checked in order.
  always @(posedge clk_i) begin
    byte_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (byte_taken) begin
      predict_byte(s_axis_tdata_i, s_axis_tlast_i);
      accepted_items++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o[7:0] != want.out_byte)
          report_mismatch("out_byte", m_axis_tdata_o[7:0], want.out_byte);
        if (m_axis_tuser_o != want.byte_present)
          report_mismatch("byte_present", m_axis_tuser_o, want.byte_present);
        if (m_axis_tlast_o != want.token_last)
          report_mismatch("token_last", m_axis_tlast_o, want.token_last);
        if (m_axis_tdata_o[8] != want.message_end)
          report_mismatch("message_end", m_axis_tdata_o[8], want.message_end);
        if (m_axis_tdata_o[9] != want.rejected)
          report_mismatch("rejected", m_axis_tdata_o[9], want.rejected);
        if (m_axis_tdata_o[10] != want.overflowed)
          report_mismatch("overflowed", m_axis_tdata_o[10], want.overflowed);
        if (want.message_end) begin
          messages_seen++;
          if (want.rejected) rejects_seen++;
        end else begin
          token_bytes_seen++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int  kind;
    logic [7:0] first;
    tokenizer_clear();

    // Header rejects: bad first byte, missing second byte, 0x01 or zero as second byte.
    msg_build.push_back(8'h41);
    queue_message(1'b0);
    msg_build.push_back(ctmt_pkg::CH_CTCP);
    queue_message(1'b0);
    msg_build.push_back(ctmt_pkg::CH_CTCP);
    msg_build.push_back(ctmt_pkg::CH_CTCP);
    msg_build.push_back(LETTER_A);
    queue_message(1'b0);
    msg_build.push_back(ctmt_pkg::CH_CTCP);
    msg_build.push_back(ctmt_pkg::CH_NUL);
    queue_message(1'b0);
    // Octal run that wraps to eight bits and is completed by the end of the message.
    // The sender first waits until every earlier result has come out.
    msg_build.push_back(ctmt_pkg::CH_CTCP);
    msg_build.push_back(ctmt_pkg::CH_BSLASH);
    msg_build.push_back(DIGIT_ZERO + 8'd4);
    msg_build.push_back(DIGIT_ZERO);
    msg_build.push_back(DIGIT_ZERO + 8'd1);
    queue_message(1'b1);
    // Quoted token with a kept space, octal and digit escapes, an escaped quote, an escaped
    // zero, skipped raw bytes, 0xFF, a dangling backslash and quotes left open.
    msg_build.push_back(ctmt_pkg::CH_CTCP);
    msg_build.push_back(ctmt_pkg::CH_QUOTE);
    msg_build.push_back(LETTER_A);
    msg_build.push_back(ctmt_pkg::CH_SPACE);
    msg_build.push_back(ctmt_pkg::CH_BSLASH);
    msg_build.push_back(DIGIT_ZERO + 8'd1);
    msg_build.push_back(DIGIT_ZERO);
    msg_build.push_back(DIGIT_ZERO + 8'd1);
    msg_build.push_back(ctmt_pkg::CH_BSLASH);
    msg_build.push_back(DIGIT_EIGHT);
    msg_build.push_back(ctmt_pkg::CH_BSLASH);
    msg_build.push_back(ctmt_pkg::CH_QUOTE);
    msg_build.push_back(ctmt_pkg::CH_BSLASH);
    msg_build.push_back(DIGIT_ZERO);
    msg_build.push_back(ctmt_pkg::CH_CTCP);
    msg_build.push_back(ctmt_pkg::CH_NUL);
    msg_build.push_back(8'hFF);
    msg_build.push_back(ctmt_pkg::CH_BSLASH);
    queue_message(1'b0);

    while (total_items < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        first = 8'($urandom_range(0, 255));
        msg_build.push_back(first == ctmt_pkg::CH_CTCP ? ctmt_pkg::CH_NUL : first);
        random_body($urandom_range(0, 4));
      end else if (kind < 10) begin
        msg_build.push_back(ctmt_pkg::CH_CTCP);
        msg_build.push_back($urandom_range(0, 1) ? ctmt_pkg::CH_CTCP : ctmt_pkg::CH_NUL);
        random_body($urandom_range(0, 4));
      end else if (kind < 13) begin
        msg_build.push_back(ctmt_pkg::CH_CTCP);
      end else begin
        msg_build.push_back(ctmt_pkg::CH_CTCP);
        random_body($urandom_range(1, 12));
        if ($urandom_range(0, 7) == 0) msg_build.push_back(ctmt_pkg::CH_BSLASH);
      end
      queue_message($urandom_range(0, 19) == 0);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_items < total_items) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes in %0d messages, %0d of them rejected at the header.",
             accepted_items, messages_seen, rejects_seen);
    $display("Checked %0d token bytes; %0d mismatches.", token_bytes_seen, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
